/* hw/rtl/cdq_pkg.sv */
// Shared types and constants for the circular deque block.
package cdq_pkg;

  // Default ring store depth
  localparam int MAX_DEPTH_DEF = 1024;

  // Field widths fixed by the item format
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int CAP_W  = 11;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Packed stream widths (padded to whole bytes)
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_t;

  // Status of one finished item, handed from control to the output stage
  typedef struct packed {
    logic ok;
    logic is_empty;
    logic is_full;
  } res_t;

endpackage

/* hw/rtl/circular_deque.sv */
// Top level of the circular deque: stream ports, store, control and output register.
//
// A bounded double-ended queue of 32-bit entries in a ring store of MAX_DEPTH
// words. Each input item carries a command (query, insert front, insert back,
// remove front, remove back) and a value; each yields one result with the
// success flag, the front and rear values after the command (-1 when empty)
// and the empty and full flags. The accepting edge of an item updates the
// pointers and writes the store; in the read state the front and rear entries
// are read into registers; in the done state the result waits until the
// output register is free or being drained, and is then loaded into it.
// Items are handled one at a time, so a new item is not accepted until the
// result of the last one is loaded; the next item is accepted while a result
// still waits in the output register. Writing cfg_data sets the
// capacity (0 acts as 1, values above MAX_DEPTH act as MAX_DEPTH) and empties
// the deque; write it only while no item is in flight. No clearing pass runs
// after reset; read data is used only for entries that were written.
module circular_deque #(
  parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: capacity
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdq_pkg::CAP_W-1:0]       cfg_data,
  // input items: [2:0] cmd, [34:3] data_in, [39:35] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // results: [0] ok, [32:1] front_value, [64:33] rear_value,
  //          [65] is_empty, [66] is_full, [71:67] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cdq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(MAX_DEPTH);
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int DW = cdq_pkg::DATA_W;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr_front;
  logic [AW-1:0]        rd_addr_rear;
  logic [DW-1:0]        rd_front;
  logic [DW-1:0]        rd_rear;
  logic                 res_valid;
  cdq_pkg::res_t        res;
  logic                 res_take;

  logic                 out_valid_r, out_valid_nxt;
  cdq_pkg::res_t        out_res_r;
  logic [DW-1:0]        out_front_r;
  logic [DW-1:0]        out_rear_r;

  assign cfg_ready = 1'b1;

  cdq_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_fire      (cfg_valid && cfg_ready),
    .cfg_cap       (cfg_data),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_cmd        (in_tdata[cdq_pkg::CMD_W-1:0]),
    .in_data       (in_tdata[cdq_pkg::CMD_W +: DW]),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr_front (rd_addr_front),
    .rd_addr_rear  (rd_addr_rear),
    .res_valid     (res_valid),
    .res           (res),
    .res_take      (res_take)
  );

  cdq_store #(
    .MAX_DEPTH (MAX_DEPTH),
    .AW        (AW)
  ) u_store (
    .clk           (clk),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr_front (rd_addr_front),
    .rd_addr_rear  (rd_addr_rear),
    .rd_front      (rd_front),
    .rd_rear       (rd_rear)
  );

  // Load the output register when it is free or being drained
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result payload; an empty deque reports -1 on both ends
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r   <= res;
      out_front_r <= res.is_empty ? '1 : rd_front;
      out_rear_r  <= res.is_empty ? '1 : rd_rear;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.is_full, out_res_r.is_empty,
                       out_rear_r, out_front_r, out_res_r.ok};

endmodule

/* hw/rtl/cdq_store.sv */
// Ring store: one write port and two registered read ports (front and rear).
module cdq_store #(
  parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEF,
  parameter int AW        = $clog2(MAX_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [cdq_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr_front,
  input  logic [AW-1:0]             rd_addr_rear,
  output logic [cdq_pkg::DATA_W-1:0] rd_front,
  output logic [cdq_pkg::DATA_W-1:0] rd_rear
);

  logic [cdq_pkg::DATA_W-1:0] mem [MAX_DEPTH];
  logic [cdq_pkg::DATA_W-1:0] rd_front_r;
  logic [cdq_pkg::DATA_W-1:0] rd_rear_r;

  // Write the inserted item
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read front and rear entries, hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_front_r <= mem[rd_addr_front];
      rd_rear_r  <= mem[rd_addr_rear];
    end
  end

  assign rd_front = rd_front_r;
  assign rd_rear  = rd_rear_r;

endmodule

/* hw/rtl/cdq_ctrl.sv */
// Deque control: capacity, head/tail pointers, occupancy and item sequencer.
module cdq_ctrl #(
  parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEF,
  parameter int AW        = $clog2(MAX_DEPTH),
  parameter int CW        = $clog2(MAX_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration write
  input  logic                       cfg_fire,
  input  logic [cdq_pkg::CAP_W-1:0]  cfg_cap,
  // item in
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cdq_pkg::CMD_W-1:0]  in_cmd,
  input  logic [cdq_pkg::DATA_W-1:0] in_data,
  // store access
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [cdq_pkg::DATA_W-1:0] wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr_front,
  output logic [AW-1:0]              rd_addr_rear,
  // finished item status
  output logic                       res_valid,
  output cdq_pkg::res_t              res,
  input  logic                       res_take
);

  localparam int XW = (CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W;
  localparam int CAP_RST_EFF =
    (int'(cdq_pkg::CAP_RESET) == 0) ? 1 :
    ((int'(cdq_pkg::CAP_RESET) > MAX_DEPTH) ? MAX_DEPTH : int'(cdq_pkg::CAP_RESET));

  cdq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  logic [CW-1:0]   cap_r, cap_nxt;
  cdq_pkg::res_t   res_r, res_nxt;

  logic            in_fire;
  logic            full;
  logic            empty;
  logic [CW-1:0]   head_p1;
  logic [CW-1:0]   tail_p1;
  logic [AW-1:0]   head_inc, head_dec;
  logic [AW-1:0]   tail_inc, tail_dec;
  logic [XW-1:0]   cfg_cap_x;
  logic [CW-1:0]   cfg_eff;
  logic            ok;
  cdq_pkg::cmd_t   cmd;

  assign in_fire = in_valid && in_ready;
  assign cmd     = cdq_pkg::cmd_t'(in_cmd);
  assign full    = (occ_r >= cap_r);
  assign empty   = (occ_r == '0);

  // Pointer steps with wraparound at the effective capacity
  assign head_p1  = CW'(head_r) + CW'(1);
  assign tail_p1  = CW'(tail_r) + CW'(1);
  assign head_inc = (head_p1 >= cap_r) ? '0 : AW'(head_p1);
  assign tail_inc = (tail_p1 >= cap_r) ? '0 : AW'(tail_p1);
  assign head_dec = (head_r == '0) ? AW'(cap_r - CW'(1)) : head_r - AW'(1);
  assign tail_dec = (tail_r == '0) ? AW'(cap_r - CW'(1)) : tail_r - AW'(1);

  // Clamp a written capacity to 1..MAX_DEPTH
  assign cfg_cap_x = XW'(cfg_cap);
  always_comb begin
    if (cfg_cap_x == '0) begin
      cfg_eff = CW'(1);
    end else if (cfg_cap_x > XW'(MAX_DEPTH)) begin
      cfg_eff = CW'(MAX_DEPTH);
    end else begin
      cfg_eff = CW'(cfg_cap_x);
    end
  end

  // Apply a capacity write or one command to pointers and count, issue the store write
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    cap_nxt  = cap_r;
    ok       = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = tail_r;
    wr_data  = in_data;
    if (cfg_fire) begin
      cap_nxt  = cfg_eff;
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
    end else if (in_fire) begin
      case (cmd)
        cdq_pkg::CMD_QUERY: begin
          ok = 1'b1;
        end
        cdq_pkg::CMD_PUSH_FRONT: begin
          if (!full) begin
            head_nxt = head_dec;
            wr_en    = 1'b1;
            wr_addr  = head_dec;
            occ_nxt  = occ_r + CW'(1);
            ok       = 1'b1;
          end
        end
        cdq_pkg::CMD_PUSH_BACK: begin
          if (!full) begin
            wr_en    = 1'b1;
            wr_addr  = tail_r;
            tail_nxt = tail_inc;
            occ_nxt  = occ_r + CW'(1);
            ok       = 1'b1;
          end
        end
        cdq_pkg::CMD_POP_FRONT: begin
          if (!empty) begin
            head_nxt = head_inc;
            occ_nxt  = occ_r - CW'(1);
            ok       = 1'b1;
          end
        end
        cdq_pkg::CMD_POP_BACK: begin
          if (!empty) begin
            tail_nxt = tail_dec;
            occ_nxt  = occ_r - CW'(1);
            ok       = 1'b1;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  // Capture status of the item as it is accepted
  always_comb begin
    res_nxt = res_r;
    if (in_fire) begin
      res_nxt.ok       = ok;
      res_nxt.is_empty = (occ_nxt == '0);
      res_nxt.is_full  = (occ_nxt >= cap_r);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cdq_pkg::ST_READ;
        end
      end
      cdq_pkg::ST_READ: begin
        state_nxt = cdq_pkg::ST_DONE;
      end
      cdq_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = cdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdq_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      cdq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      cdq_pkg::ST_READ: begin
        rd_en = 1'b1;
      end
      cdq_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Read front at head and rear just before tail, after the update
  assign rd_addr_front = head_r;
  assign rd_addr_rear  = tail_dec;
  assign res           = res_r;

  // Advance registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      cap_r   <= CW'(CAP_RST_EFF);
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // Occupancy never exceeds the capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cap_r)
    else $error("occupancy above capacity");

  // Pointers stay inside the ring
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(head_r) < cap_r) && (CW'(tail_r) < cap_r))
    else $error("pointer outside ring");

  // An accepted item goes on to the store read
  a_fire_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == cdq_pkg::ST_READ))
    else $error("accepted item did not reach read");

  // Head and tail must meet whenever the deque is empty or full
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_r == '0) || (occ_r == cap_r)) |-> (head_r == tail_r))
    else $error("pointers disagree with occupancy");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the circular deque: directed table, random phases, shadow deque.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_W       = cdq_pkg::CMD_W;
  localparam int DATA_W      = cdq_pkg::DATA_W;
  localparam int CAP_W       = cdq_pkg::CAP_W;
  localparam int IN_TDATA_W  = cdq_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = cdq_pkg::OUT_TDATA_W;

  localparam int DEPTH           = cdq_pkg::MAX_DEPTH_DEF;
  localparam int PTR_W           = $clog2(DEPTH);
  localparam int IDLE_LIMIT      = 2000;
  localparam int LONG_HOLD       = 400;
  localparam int REPORT_CAP      = 60;
  localparam int NUM_PHASES      = 13;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int HOLD_PHASE      = 2;

  // Command codes outside the defined set
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNDEF_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI  = 3'd7;

  localparam logic [DATA_W-1:0] EMPTY_MARK = '1;
  localparam logic [DATA_W-1:0] MAX_POS    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN_NEG    = 32'h8000_0000;

  // Fields of one result, in the order they are checked
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] rear;
    logic              empty;
    logic              full;
  } deque_status_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CAP_W-1:0]  cap;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
    logic              typed;
    deque_status_t     exp;
  } step_row_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_t;

  localparam deque_status_t NO_EXP      = '0;
  localparam deque_status_t EMPTY_OK    = '{1'b1, EMPTY_MARK, EMPTY_MARK, 1'b1, 1'b0};
  localparam deque_status_t EMPTY_NO    = '{1'b0, EMPTY_MARK, EMPTY_MARK, 1'b1, 1'b0};
  localparam deque_status_t ONE_FULL_OK = '{1'b1, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1};
  localparam deque_status_t ONE_FULL_NO = '{1'b0, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1};

  localparam int NUM_ROWS = 29;

  // Directed table: reset state, extremes, unknown codes, capacity clamping
  localparam step_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_QUERY,      32'd0,         1'b1, EMPTY_OK},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_FRONT,  32'd0,         1'b1, EMPTY_NO},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_BACK,   32'hFFFF_FFFF, 1'b1, EMPTY_NO},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_BACK,  MAX_POS,       1'b1,
      '{1'b1, MAX_POS, MAX_POS, 1'b0, 1'b0}},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_FRONT, MIN_NEG,       1'b1,
      '{1'b1, MIN_NEG, MAX_POS, 1'b0, 1'b0}},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_BACK,  32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_FRONT, EMPTY_MARK,    1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    CMD_UNDEF_LO,            32'hDEAD_BEEF, 1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_BACK,   32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_FRONT,  32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_BACK,   32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_FRONT,  32'd0,         1'b0, NO_EXP},
    '{ROW_CFG,  11'd0,    cdq_pkg::CMD_QUERY,      32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_FRONT, 32'h1234_5678, 1'b1, ONE_FULL_OK},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_BACK,  32'h0000_0055, 1'b1, ONE_FULL_NO},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0066, 1'b1, ONE_FULL_NO},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_BACK,   32'd0,         1'b1, EMPTY_OK},
    '{ROW_ITEM, 11'd0,    CMD_UNDEF_MID,           32'd0,         1'b1, EMPTY_NO},
    '{ROW_CFG,  11'd2047, cdq_pkg::CMD_QUERY,      32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_BACK,  32'hA5A5_A5A5, 1'b0, NO_EXP},
    '{ROW_CFG,  11'd2047, cdq_pkg::CMD_QUERY,      32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_QUERY,      32'd0,         1'b1, EMPTY_OK},
    '{ROW_CFG,  11'd2,    cdq_pkg::CMD_QUERY,      32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_FRONT, 32'h0000_0001, 1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_BACK,  32'h0000_0002, 1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_PUSH_BACK,  32'h0000_0003, 1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_FRONT,  32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_BACK,   32'd0,         1'b0, NO_EXP},
    '{ROW_ITEM, 11'd0,    cdq_pkg::CMD_POP_BACK,   32'd0,         1'b0, NO_EXP}
  };

  // Capacities of the random phases; every fifth phase draws its own
  localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
    11'd1, 11'd2, 11'd3, 11'd0, 11'd0, 11'd5, 11'd2047, 11'd8, 11'd1024, 11'd0,
    11'd13, 11'd31, 11'd4
  };

  // Percentage of pushes among pushes and pops, cycled over the phases
  localparam int PUSH_BIAS [3] = '{70, 30, 50};

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the deque
  logic [DATA_W-1:0] shadow_store [DEPTH];
  logic [PTR_W-1:0]  shadow_head;
  logic [PTR_W-1:0]  shadow_tail;
  logic [CAP_W-1:0]  shadow_count;
  logic [CAP_W-1:0]  shadow_cap;

  deque_status_t pending_status [$];
  int            fail_count;
  int            burst_left;
  bit            long_hold_req;

  circular_deque uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [CAP_W-1:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= shadow_cap) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    logic [CAP_W-1:0] last;
    last = shadow_cap - 1'b1;
    return (p == '0) ? last[PTR_W-1:0] : p - 1'b1;
  endfunction

  // Apply one command to the shadow deque and return the status it leaves
  function automatic deque_status_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [DATA_W-1:0] data);
    deque_status_t s;
    logic          full;
    logic          empty;
    full  = (shadow_count >= shadow_cap);
    empty = (shadow_count == '0);
    s = '0;
    case (cmd)
      cdq_pkg::CMD_QUERY: begin
        s.ok = 1'b1;
      end
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (!full) begin
          shadow_head = ptr_prev(shadow_head);
          shadow_store[shadow_head] = data;
          shadow_count = shadow_count + 1'b1;
          s.ok = 1'b1;
        end
      end
      cdq_pkg::CMD_PUSH_BACK: begin
        if (!full) begin
          shadow_store[shadow_tail] = data;
          shadow_tail = ptr_next(shadow_tail);
          shadow_count = shadow_count + 1'b1;
          s.ok = 1'b1;
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (!empty) begin
          shadow_head = ptr_next(shadow_head);
          shadow_count = shadow_count - 1'b1;
          s.ok = 1'b1;
        end
      end
      cdq_pkg::CMD_POP_BACK: begin
        if (!empty) begin
          shadow_tail = ptr_prev(shadow_tail);
          shadow_count = shadow_count - 1'b1;
          s.ok = 1'b1;
        end
      end
      default: ;
    endcase
    s.front = EMPTY_MARK;
    s.rear  = EMPTY_MARK;
    if (shadow_count != '0) begin
      s.front = shadow_store[shadow_head];
      s.rear  = shadow_store[ptr_prev(shadow_tail)];
    end
    s.empty = (shadow_count == '0);
    s.full  = (shadow_count >= shadow_cap);
    return s;
  endfunction

  // Offer one item, record its expected status, then pace the next one
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data,
                              input logic typed, input deque_status_t typed_exp);
    deque_status_t predicted;
    int            gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-CMD_W-DATA_W){1'b0}}, data, cmd};
    do @(posedge clk); while (!in_tready);
    predicted = apply_command(cmd, data);
    pending_status.insert(pending_status.size(), typed ? typed_exp : predicted);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drain all results, then write the capacity and empty the shadow deque
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (value == '0)
      shadow_cap = CAP_W'(1);
    else if (value > DEPTH)
      shadow_cap = CAP_W'(DEPTH);
    else
      shadow_cap = value;
    shadow_head  = '0;
    shadow_tail  = '0;
    shadow_count = '0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    deque_status_t got;
    deque_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[0], out_tdata[32:1], out_tdata[64:33], out_tdata[65], out_tdata[66]};
      if (pending_status.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP)
          $display("%0t: unexpected result, expected none got %h", $time, got);
      end else begin
        want = pending_status[0];
        pending_status.delete(0);
        check_field("ok",          want.ok,    got.ok);
        check_field("front_value", want.front, got.front);
        check_field("rear_value",  want.rear,  got.rear);
        check_field("is_empty",    want.empty, got.empty);
        check_field("is_full",     want.full,  got.full);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no item moved for %0d cycles", $time, idle);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Stall the result side in changing patterns, with one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       left;
    int       tick;
    out_tready = 1'b0;
    mode = RX_ALWAYS;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(10, 80);
      end
      left--;
      tick++;
      case (mode)
        RX_ALWAYS:      out_tready <= 1'b1;
        RX_COIN:        out_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE:      out_tready <= ($urandom_range(0, 3) == 0);
        RX_EVERY_THIRD: out_tready <= (tick % 3 == 0);
        default:        out_tready <= 1'b1;
      endcase
    end
  end

  // Stimulus: reset, directed table, random phases, drain
  initial begin
    logic [CAP_W-1:0]  cap;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
    int                push_pct;
    int                pick;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    fail_count    = 0;
    burst_left    = 0;
    long_hold_req = 1'b0;
    shadow_cap    = cdq_pkg::CAP_RESET;
    shadow_head   = '0;
    shadow_tail   = '0;
    shadow_count  = '0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG)
        write_capacity(DIRECTED[r].cap);
      else
        send_command(DIRECTED[r].cmd, DIRECTED[r].data, DIRECTED[r].typed, DIRECTED[r].exp);
    end

    // Random phases, each with its own capacity and push/pop balance
    for (int p = 0; p < NUM_PHASES; p++) begin
      cap = (p % 5 == 4) ? CAP_W'($urandom_range(1, 64)) : PHASE_CAPS[p];
      write_capacity(cap);
      if (p == HOLD_PHASE)
        long_hold_req = 1'b1;
      push_pct = PUSH_BIAS[p % 3];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3)
          cmd = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        else if (pick < 8)
          cmd = cdq_pkg::CMD_QUERY;
        else if ($urandom_range(0, 99) < push_pct)
          cmd = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_BACK;
        else
          cmd = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_BACK;
        case ($urandom_range(0, 7))
          0:       data = '0;
          1:       data = EMPTY_MARK;
          2:       data = MIN_NEG;
          3:       data = MAX_POS;
          default: data = $urandom;
        endcase
        send_command(cmd, data, 1'b0, NO_EXP);
      end
    end

    // Drain and let the pipeline settle
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_status.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_store.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/circular_deque.sv
bench/tb_top.sv
